/* hw/rtl/pulse_width_sensor_frame_decoder_unit_defines.svh */
// Assertion macros for the pulse-width sensor frame decoder
`ifndef PULSE_WIDTH_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH
`define PULSE_WIDTH_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PWSFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pwsfd: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PWSFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pwsfd: next-cycle check failed");

`endif

/* hw/rtl/pwsfd_pkg.sv */
// Shared types and constants for the pulse-width sensor frame decoder
package pwsfd_pkg;

    localparam int FRAME_BITS = 40;
    localparam int IV_W       = 16;
    localparam int CNT_W      = 8;
    localparam int BITCNT_W   = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [IV_W-1:0] INTERVAL_MIN_RST  = 16'd50;
    localparam logic [IV_W-1:0] INTERVAL_MAX_RST  = 16'd150;
    localparam logic [IV_W-1:0] ONE_THRESHOLD_RST = 16'd110;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_EDGE   = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMING   = 2'd1,
        ST_BITCOUNT = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL_MIN  = 2'd0,
        CFG_INTERVAL_MAX  = 2'd1,
        CFG_ONE_THRESHOLD = 2'd2,
        CFG_SENSOR_MODEL  = 2'd3
    } cfg_idx_t;

endpackage

/* hw/rtl/pulse_width_sensor_frame_decoder_unit.sv */
// Pulse-width sensor frame decoder: input register, frame state and result register
//
// Input channel (s_valid/s_ready) carries a function code and an edge interval:
// start clears the frame, edge classifies one interval between falling edges,
// finish reports the frame. Only finish produces a result transfer on the
// m_ channel (status, 40 received bits, humidity, temperature, counts).
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); the user is
// to write it only while the block is idle, as the block does not enforce this;
// sensor_model takes cfg_wdata bit 0. A finish passes from the input register into
// the result register, whose valid bit drives m_valid. Throughput: one item per
// cycle while no finish waits behind a held result; the input register and the
// result register each take a new item whenever they are empty or are being
// emptied. When the receiver stalls, the result holds in the result register;
// the input register still takes one more item, and edge and start items keep
// flowing past a held result, since they produce no transfer.
// Reset (aresetn low, synchronous) empties both registers, clears the frame
// and loads the configuration defaults 50, 150, 110 and model 1.
module pulse_width_sensor_frame_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pwsfd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pwsfd_pkg::IV_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [pwsfd_pkg::IV_W-1:0]          s_interval,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [pwsfd_pkg::FRAME_BITS-1:0]    m_frame_bytes,
    output logic [15:0]                         m_humidity_raw,
    output logic signed [15:0]                  m_temperature_raw,
    output logic [pwsfd_pkg::CNT_W-1:0]         m_edge_total,
    output logic [pwsfd_pkg::CNT_W-1:0]         m_error_total,
    output logic [pwsfd_pkg::BITCNT_W-1:0]      m_bits_received
);
    import pwsfd_pkg::*;

    `include "pulse_width_sensor_frame_decoder_unit_defines.svh"

    localparam logic [CNT_W-1:0]    CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [BITCNT_W-1:0] FRAME_CNT = BITCNT_W'(FRAME_BITS);
    localparam logic [BITCNT_W-1:0] LAST_POS  = BITCNT_W'(FRAME_BITS - 1);

    logic [IV_W-1:0] int_min_reg;
    logic [IV_W-1:0] int_max_reg;
    logic [IV_W-1:0] thr_reg;
    logic            model_reg;

    logic            in_vld_reg, in_vld_next;
    func_t           in_func_reg;
    logic [IV_W-1:0] in_iv_reg;

    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [BITCNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]      err_cnt_reg, err_cnt_next;
    logic [CNT_W-1:0]      edge_cnt_reg, edge_cnt_next;
    logic                  start_seen_reg, start_seen_next;

    logic                  out_vld_reg, out_vld_next;
    status_t               out_status_reg, out_status_next;
    logic [FRAME_BITS-1:0] out_frame_reg;
    logic [15:0]           out_hum_reg, out_hum_next;
    logic [15:0]           out_temp_reg, out_temp_next;
    logic [CNT_W-1:0]      out_edge_reg;
    logic [CNT_W-1:0]      out_err_reg;
    logic [BITCNT_W-1:0]   out_bits_reg;

    logic                  advance;
    logic                  load_out;
    logic                  iv_long;
    logic                  iv_bad;
    logic [BITCNT_W-1:0]   bit_pos;
    logic [7:0]            b0, b1, b2, b3, b4;
    logic [7:0]            sum8;
    logic [14:0]           mag;

    logic                  start_adv;
    logic                  frame_idle;
    logic                  edge_full;
    logic                  out_has_err;
    logic                  out_short;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_min_reg <= INTERVAL_MIN_RST;
            int_max_reg <= INTERVAL_MAX_RST;
            thr_reg     <= ONE_THRESHOLD_RST;
            model_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_INTERVAL_MIN:  int_min_reg <= cfg_wdata;
                CFG_INTERVAL_MAX:  int_max_reg <= cfg_wdata;
                CFG_ONE_THRESHOLD: thr_reg     <= cfg_wdata;
                CFG_SENSOR_MODEL:  model_reg   <= cfg_wdata[0];
                default:           model_reg   <= model_reg;
            endcase
        end
    end

    // handshake
    assign advance  = in_vld_reg && ((in_func_reg != FUNC_FINISH) || !out_vld_reg || m_ready);
    assign load_out = advance && (in_func_reg == FUNC_FINISH);
    assign s_ready  = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_ready) begin
            in_vld_next = s_valid;
        end
        out_vld_next = out_vld_reg;
        if (load_out) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    // frame update
    assign iv_long = in_iv_reg > int_max_reg;
    assign iv_bad  = (in_iv_reg < int_min_reg) || iv_long;
    assign bit_pos = LAST_POS - bit_cnt_reg;

    always_comb begin
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        err_cnt_next    = err_cnt_reg;
        edge_cnt_next   = edge_cnt_reg;
        start_seen_next = start_seen_reg;
        if (advance) begin
            unique case (in_func_reg)
                FUNC_START: begin
                    shift_next      = '0;
                    bit_cnt_next    = '0;
                    err_cnt_next    = '0;
                    edge_cnt_next   = '0;
                    start_seen_next = 1'b0;
                end
                FUNC_EDGE: begin
                    if (edge_cnt_reg != CNT_MAX) begin
                        edge_cnt_next = edge_cnt_reg + 1'b1;
                    end
                    priority if (iv_long && !start_seen_reg) begin
                        start_seen_next = 1'b1;
                    end else if (iv_bad || (bit_cnt_reg >= FRAME_CNT)) begin
                        if (err_cnt_reg != CNT_MAX) begin
                            err_cnt_next = err_cnt_reg + 1'b1;
                        end
                    end else begin
                        if (in_iv_reg > thr_reg) begin
                            shift_next[bit_pos] = 1'b1;
                        end
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                    end
                end
                default: begin
                    shift_next = shift_reg;
                end
            endcase
        end
    end

    // report
    assign b0   = shift_reg[39:32];
    assign b1   = shift_reg[31:24];
    assign b2   = shift_reg[23:16];
    assign b3   = shift_reg[15:8];
    assign b4   = shift_reg[7:0];
    assign sum8 = b0 + b1 + b2 + b3;
    assign mag  = {b2[6:0], b3};

    always_comb begin
        priority if (err_cnt_reg != '0) begin
            out_status_next = ST_TIMING;
        end else if (bit_cnt_reg != FRAME_CNT) begin
            out_status_next = ST_BITCOUNT;
        end else if (sum8 != b4) begin
            out_status_next = ST_CHECKSUM;
        end else begin
            out_status_next = ST_OK;
        end
        if (model_reg) begin
            out_hum_next  = {b0, b1};
            out_temp_next = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
        end else begin
            out_hum_next  = {8'd0, b0};
            out_temp_next = {8'd0, b2};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            shift_reg      <= '0;
            bit_cnt_reg    <= '0;
            err_cnt_reg    <= '0;
            edge_cnt_reg   <= '0;
            start_seen_reg <= 1'b0;
        end else begin
            in_vld_reg     <= in_vld_next;
            out_vld_reg    <= out_vld_next;
            shift_reg      <= shift_next;
            bit_cnt_reg    <= bit_cnt_next;
            err_cnt_reg    <= err_cnt_next;
            edge_cnt_reg   <= edge_cnt_next;
            start_seen_reg <= start_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_func_reg <= func_t'(s_func);
            in_iv_reg   <= s_interval;
        end
        if (load_out) begin
            out_status_reg <= out_status_next;
            out_frame_reg  <= shift_reg;
            out_hum_reg    <= out_hum_next;
            out_temp_reg   <= out_temp_next;
            out_edge_reg   <= edge_cnt_reg;
            out_err_reg    <= err_cnt_reg;
            out_bits_reg   <= bit_cnt_reg;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_status          = out_status_reg;
    assign m_frame_bytes     = out_frame_reg;
    assign m_humidity_raw    = out_hum_reg;
    assign m_temperature_raw = out_temp_reg;
    assign m_edge_total      = out_edge_reg;
    assign m_error_total     = out_err_reg;
    assign m_bits_received   = out_bits_reg;

    assign start_adv   = advance && (in_func_reg == FUNC_START);
    assign frame_idle  = (bit_cnt_reg == '0) && (edge_cnt_reg == '0) && (err_cnt_reg == '0)
                         && !start_seen_reg;
    assign edge_full   = edge_cnt_reg == CNT_MAX;
    assign out_has_err = out_vld_reg && (out_err_reg != '0);
    assign out_short   = out_vld_reg && (out_err_reg == '0) && (out_bits_reg != FRAME_CNT);

    `PWSFD_ASSERT_NOW(a_bit_cnt_bound, aclk, aresetn, 1'b1, bit_cnt_reg <= FRAME_CNT)
    `PWSFD_ASSERT_NEXT(a_start_clears, aclk, aresetn, start_adv, frame_idle)
    `PWSFD_ASSERT_NEXT(a_edge_saturates, aclk, aresetn, edge_full && !start_adv, edge_full)
    `PWSFD_ASSERT_NOW(a_timing_first, aclk, aresetn, out_has_err, out_status_reg == ST_TIMING)
    `PWSFD_ASSERT_NOW(a_count_status, aclk, aresetn, out_short, out_status_reg == ST_BITCOUNT)

endmodule

/* tb/pwsfd_report_check.sv */
`timescale 1ns / 1ps
// Frame report checker: tracks the decoder frame state and compares every result transfer
module pwsfd_report_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pwsfd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pwsfd_pkg::IV_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [pwsfd_pkg::IV_W-1:0]          s_interval,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [1:0]                          m_status,
    input  logic [pwsfd_pkg::FRAME_BITS-1:0]    m_frame_bytes,
    input  logic [15:0]                         m_humidity_raw,
    input  logic signed [15:0]                  m_temperature_raw,
    input  logic [pwsfd_pkg::CNT_W-1:0]         m_edge_total,
    input  logic [pwsfd_pkg::CNT_W-1:0]         m_error_total,
    input  logic [pwsfd_pkg::BITCNT_W-1:0]      m_bits_received,
    output int                                  fail_count,
    output int                                  pending
);
    import pwsfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t                status;
        logic [FRAME_BITS-1:0]  frame;
        logic [15:0]            humidity;
        logic signed [15:0]     temperature;
        logic [CNT_W-1:0]       edges;
        logic [CNT_W-1:0]       errors;
        logic [BITCNT_W-1:0]    bits;
    } frame_report_t;

    logic [IV_W-1:0]        min_iv;
    logic [IV_W-1:0]        max_iv;
    logic [IV_W-1:0]        one_iv;
    logic                   tenths_model;
    logic [FRAME_BITS-1:0]  frame_sr;
    logic [BITCNT_W-1:0]    bit_cnt;
    logic [CNT_W-1:0]       err_cnt;
    logic [CNT_W-1:0]       edge_cnt;
    logic                   synced;
    frame_report_t          report_q[$];
    int                     mismatches = 0;

    function automatic void clear_frame();
        frame_sr = '0;
        bit_cnt  = '0;
        err_cnt  = '0;
        edge_cnt = '0;
        synced   = 1'b0;
    endfunction

    function automatic void bump_errors();
        if (err_cnt != '1)
            err_cnt++;
    endfunction

    function automatic void take_interval(input logic [IV_W-1:0] iv);
        if (edge_cnt != '1)
            edge_cnt++;
        if (iv > max_iv && !synced) begin
            synced = 1'b1;
        end else if (iv < min_iv || iv > max_iv) begin
            bump_errors();
        end else if (bit_cnt < FRAME_BITS) begin
            if (iv > one_iv)
                frame_sr[FRAME_BITS-1-bit_cnt] = 1'b1;
            bit_cnt++;
        end else begin
            bump_errors();
        end
    endfunction

    function automatic frame_report_t frame_report();
        frame_report_t r;
        logic [7:0]    b0, b1, b2, b3, b4, sum;
        logic [15:0]   mag;
        b0  = frame_sr[39:32];
        b1  = frame_sr[31:24];
        b2  = frame_sr[23:16];
        b3  = frame_sr[15:8];
        b4  = frame_sr[7:0];
        sum = b0 + b1 + b2 + b3;
        if (err_cnt != 0)
            r.status = ST_TIMING;
        else if (bit_cnt != FRAME_BITS)
            r.status = ST_BITCOUNT;
        else if (sum != b4)
            r.status = ST_CHECKSUM;
        else
            r.status = ST_OK;
        if (!tenths_model) begin
            r.humidity    = {8'h00, b0};
            r.temperature = {8'h00, b2};
        end else begin
            mag           = {1'b0, b2[6:0], b3};
            r.humidity    = {b0, b1};
            r.temperature = b2[7] ? -mag : mag;
        end
        r.frame  = frame_sr;
        r.edges  = edge_cnt;
        r.errors = err_cnt;
        r.bits   = bit_cnt;
        return r;
    endfunction

    function automatic string show(input frame_report_t r);
        return $sformatf("status %0d bytes %010h hum %04h temp %0d edges %0d errors %0d bits %0d",
                         r.status, r.frame, r.humidity, $signed(r.temperature),
                         r.edges, r.errors, r.bits);
    endfunction

    function automatic void flag(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        frame_report_t got;
        frame_report_t want;
        if (!aresetn) begin
            min_iv       = INTERVAL_MIN_RST;
            max_iv       = INTERVAL_MAX_RST;
            one_iv       = ONE_THRESHOLD_RST;
            tenths_model = 1'b1;
            clear_frame();
            report_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_INTERVAL_MIN:  min_iv = cfg_wdata;
                    CFG_INTERVAL_MAX:  max_iv = cfg_wdata;
                    CFG_ONE_THRESHOLD: one_iv = cfg_wdata;
                    CFG_SENSOR_MODEL:  tenths_model = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (func_t'(s_func))
                    FUNC_START:  clear_frame();
                    FUNC_EDGE:   take_interval(s_interval);
                    FUNC_FINISH: report_q.push_back(frame_report());
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.status      = status_t'(m_status);
                got.frame       = m_frame_bytes;
                got.humidity    = m_humidity_raw;
                got.temperature = m_temperature_raw;
                got.edges       = m_edge_total;
                got.errors      = m_error_total;
                got.bits        = m_bits_received;
                if (report_q.size() == 0) begin
                    flag({"result with nothing expected: ", show(got)});
                end else begin
                    want = report_q.pop_front();
                    if (got !== want)
                        flag({"result mismatch: expected ", show(want), " got ", show(got)});
                end
            end
        end
        fail_count <= mismatches;
        pending    <= report_q.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the pulse-width frame decoder
module tb;
    import pwsfd_pkg::*;

    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    cfg_idx_t               cfg_addr;
    logic [IV_W-1:0]        cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    func_t                  s_func;
    logic [IV_W-1:0]        s_interval;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_status;
    logic [FRAME_BITS-1:0]  m_frame_bytes;
    logic [15:0]            m_humidity_raw;
    logic signed [15:0]     m_temperature_raw;
    logic [CNT_W-1:0]       m_edge_total;
    logic [CNT_W-1:0]       m_error_total;
    logic [BITCNT_W-1:0]    m_bits_received;

    int                     fail_count;
    int                     pending;
    int                     s_idle_pct;
    int                     m_idle_pct;
    bit                     stall_req;
    int                     stuck_cycles;
    int                     items_sent;
    int                     reports_asked;
    logic [15:0]            cur_lo;
    logic [15:0]            cur_hi;
    logic [15:0]            cur_thr;

    pulse_width_sensor_frame_decoder_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_interval        (s_interval),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_frame_bytes     (m_frame_bytes),
        .m_humidity_raw    (m_humidity_raw),
        .m_temperature_raw (m_temperature_raw),
        .m_edge_total      (m_edge_total),
        .m_error_total     (m_error_total),
        .m_bits_received   (m_bits_received)
    );

    pwsfd_report_check report_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_interval        (s_interval),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_frame_bytes     (m_frame_bytes),
        .m_humidity_raw    (m_humidity_raw),
        .m_temperature_raw (m_temperature_raw),
        .m_edge_total      (m_edge_total),
        .m_error_total     (m_error_total),
        .m_bits_received   (m_bits_received),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random back-pressure, or a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    task automatic send_item(input func_t f, input logic [15:0] iv);
        @(negedge aclk);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= f;
        s_interval <= iv;
        if (f != FUNC_UNUSED)
            items_sent++;
        if (f == FUNC_FINISH)
            reports_asked++;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [15:0] lo, input logic [15:0] hi,
                                  input logic [15:0] thr, input logic model);
        logic [14:0] junk;
        junk = 15'($urandom);
        pause_until_drained();
        write_reg(CFG_INTERVAL_MIN, lo);
        write_reg(CFG_INTERVAL_MAX, hi);
        write_reg(CFG_ONE_THRESHOLD, thr);
        write_reg(CFG_SENSOR_MODEL, {junk, model});
        cur_lo  = lo;
        cur_hi  = hi;
        cur_thr = thr;
    endtask

    function automatic logic [15:0] bit_interval(input logic b);
        int lo_v, hi_v, thr_v;
        lo_v  = cur_lo;
        hi_v  = cur_hi;
        thr_v = cur_thr;
        if (b && thr_v < hi_v)
            lo_v = (thr_v + 1 > lo_v) ? thr_v + 1 : lo_v;
        else if (!b && lo_v <= thr_v)
            hi_v = (thr_v < hi_v) ? thr_v : hi_v;
        if (lo_v > hi_v)
            return 16'($urandom);
        return 16'($urandom_range(hi_v, lo_v));
    endfunction

    function automatic logic [15:0] bad_interval();
        if (cur_lo > 0 && (cur_hi == 16'hFFFF || $urandom_range(1) == 1))
            return 16'($urandom_range(cur_lo - 1, 0));
        if (cur_hi < 16'hFFFF)
            return 16'($urandom_range(16'hFFFF, cur_hi + 1));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] long_interval();
        if (cur_hi == 16'hFFFF)
            return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF, cur_hi + 1));
    endfunction

    task automatic send_full_frame();
        logic [39:0] word;
        int          flaw, bad_pos, bits_n;
        word[39:8] = $urandom;
        word[7:0]  = word[39:32] + word[31:24] + word[23:16] + word[15:8];
        if ($urandom_range(9) == 0)
            word[7:0] = 8'($urandom);
        flaw    = $urandom_range(9);
        bad_pos = $urandom_range(39);
        bits_n  = (flaw == 1) ? $urandom_range(39) : ((flaw == 2) ? 41 + $urandom_range(2) : 40);
        send_item(FUNC_START, 16'($urandom));
        send_item(FUNC_EDGE, long_interval());
        for (int k = 0; k < bits_n; k++)
            send_item(FUNC_EDGE, (flaw == 0 && k == bad_pos) ? bad_interval()
                                 : bit_interval((k < 40) ? word[39-k] : 1'($urandom)));
        send_item(FUNC_FINISH, 16'($urandom));
        if ($urandom_range(4) == 0)
            send_item(FUNC_FINISH, 16'($urandom));
    endtask

    task automatic send_short_frame();
        int n;
        n = $urandom_range(12);
        send_item(FUNC_START, 16'($urandom));
        if ($urandom_range(3) != 0)
            send_item(FUNC_EDGE, long_interval());
        repeat (n)
            send_item(FUNC_EDGE, ($urandom_range(2) == 0) ? 16'($urandom)
                                 : bit_interval(1'($urandom)));
        send_item(FUNC_FINISH, 16'($urandom));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(6, 1))
            send_item(func_t'($urandom_range(3)), 16'($urandom));
        send_item(FUNC_FINISH, 16'($urandom));
    endtask

    task automatic run_traffic(input int item_goal, input int report_goal);
        int items_at, reports_at, pick;
        items_at   = items_sent;
        reports_at = reports_asked;
        while (items_sent - items_at < item_goal || reports_asked - reports_at < report_goal) begin
            pick = $urandom_range(9);
            if (pick < 3)
                send_full_frame();
            else if (pick < 7)
                send_short_frame();
            else
                send_noise();
        end
    endtask

    task automatic saturate_counts();
        send_item(FUNC_START, 16'h0000);
        send_item(FUNC_EDGE, long_interval());
        repeat (258) send_item(FUNC_EDGE, bad_interval());
        send_item(FUNC_FINISH, 16'h0000);
    endtask

    task automatic hold_receiver_burst();
        stall_req = 1'b1;
        repeat (3) send_item(FUNC_FINISH, 16'($urandom));
        send_item(FUNC_START, 16'($urandom));
        send_item(FUNC_EDGE, bit_interval(1'b1));
        repeat (4) send_item(FUNC_FINISH, 16'($urandom));
        pause_until_drained();
    endtask

    initial begin
        int lo_pick, hi_pick;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_INTERVAL_MIN;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_func        = FUNC_START;
        s_interval    = '0;
        s_idle_pct    = 15;
        m_idle_pct    = 55;
        stall_req     = 1'b0;
        items_sent    = 0;
        reports_asked = 0;
        cur_lo        = INTERVAL_MIN_RST;
        cur_hi        = INTERVAL_MAX_RST;
        cur_thr       = ONE_THRESHOLD_RST;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        send_item(FUNC_FINISH, 16'h0000);
        send_item(FUNC_UNUSED, 16'hFFFF);
        send_item(FUNC_START, 16'hFFFF);
        send_item(FUNC_EDGE, 16'd100);
        send_item(FUNC_EDGE, 16'd120);
        send_item(FUNC_EDGE, 16'd151);
        send_item(FUNC_EDGE, 16'd49);
        send_item(FUNC_EDGE, 16'd50);
        send_item(FUNC_EDGE, 16'd150);
        send_item(FUNC_EDGE, 16'd110);
        send_item(FUNC_EDGE, 16'd111);
        send_item(FUNC_EDGE, 16'd0);
        send_item(FUNC_EDGE, 16'hFFFF);
        send_item(FUNC_FINISH, 16'h0000);
        send_item(FUNC_FINISH, 16'hFFFF);
        send_item(FUNC_START, 16'h0000);
        send_item(FUNC_FINISH, 16'h0000);

        apply_settings(16'd0, 16'hFFFF, 16'd32767, 1'b0);
        run_traffic(40, 6);
        apply_settings(16'd20, 16'd200, 16'd100, 1'b1);
        run_traffic(40, 6);

        s_idle_pct = 55;
        m_idle_pct = 15;
        apply_settings(16'd300, 16'd100, 16'd0, 1'b0);
        run_traffic(30, 5);
        apply_settings(16'd50, 16'd150, 16'hFFFF, 1'b1);
        run_traffic(30, 5);

        s_idle_pct = 0;
        m_idle_pct = 0;
        apply_settings(16'd20, 16'd200, 16'd100, 1'b1);
        saturate_counts();
        hold_receiver_burst();
        lo_pick = $urandom_range(1000);
        hi_pick = lo_pick + $urandom_range(3000, 10);
        apply_settings(16'(lo_pick), 16'(hi_pick), 16'($urandom_range(hi_pick, lo_pick)),
                       1'($urandom));
        run_traffic(40, 6);

        pause_until_drained();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pwsfd_pkg.sv
hw/rtl/pulse_width_sensor_frame_decoder_unit.sv
tb/pwsfd_report_check.sv
tb/tb.sv
